// File: rtl/image_window_pooling_core_defines.svh
// Assertion macros for the image window pooling core.
// Included by the modules that carry concurrent checks; needs signals clock and reset in scope.
`ifndef IMAGE_WINDOW_POOLING_CORE_DEFINES_SVH
`define IMAGE_WINDOW_POOLING_CORE_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Check a property, held off while reset is high.
`define IWP_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
// Check a property at every edge, reset included.
`define IWP_ASSERT_RESET(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);
`else
`define IWP_ASSERT(label, prop, msg)
`define IWP_ASSERT_RESET(label, prop, msg)
`endif
`endif

// File: rtl/iwp_pkg.sv
// Shared types and constants of the image window pooling core.
// No dependencies; compiled before every other file.
`default_nettype none
package iwp_pkg;
   localparam int PIX_IN_BITS     = 16;
   localparam int OUT_BITS        = 30;
   localparam int ROW_BITS        = 16;
   localparam int OCOL_BITS       = 10;
   localparam int OP_BITS         = 3;
   localparam int POOL_REG_BITS   = 4;
   localparam int WIDTH_REG_BITS  = 11;
   localparam int HEIGHT_REG_BITS = 16;
   localparam int CSR_DATA_BITS   = 32;
   localparam int CSR_ADDR_BITS   = 4;

   localparam logic [OP_BITS-1:0] OP_MAX    = 3'd0;
   localparam logic [OP_BITS-1:0] OP_MIN    = 3'd1;
   localparam logic [OP_BITS-1:0] OP_SUM    = 3'd2;
   localparam logic [OP_BITS-1:0] OP_MEAN   = 3'd3;
   localparam logic [OP_BITS-1:0] OP_MEDIAN = 3'd4;

   typedef enum logic [1:0] {
      REG_OP_MODE      = 2'd0,
      REG_POOL_SIZE    = 2'd1,
      REG_IMAGE_WIDTH  = 2'd2,
      REG_IMAGE_HEIGHT = 2'd3
   } reg_index_type;

   typedef enum logic [6:0] {
      S_IDLE   = 7'b0000001,
      S_STATS  = 7'b0000010,
      S_DECIDE = 7'b0000100,
      S_SEL_A  = 7'b0001000,
      S_SEL_B  = 7'b0010000,
      S_DIV    = 7'b0100000,
      S_LOAD   = 7'b1000000
   } state_type;

   typedef struct packed {
      logic accept;
      logic scan_start;
      logic scan_sel;
      logic sel_init;
      logic sel_round_b;
      logic div_start;
      logic load;
   } cmd_type;

   typedef struct packed {
      logic win_end;
      logic pass_done;
      logic sel_last;
      logic n_zero;
      logic n_odd;
      logic div_done;
      logic rsp_free;
      logic rsp_valid;
   } status_type;
endpackage
`default_nettype wire

// File: rtl/iwp_stream_if.sv
// Valid/ready channel interfaces for pixel beats and result beats.
// Depends on iwp_pkg for field widths.
`default_nettype none
interface iwp_req_if;
   logic                             valid;
   logic                             ready;
   logic [iwp_pkg::PIX_IN_BITS-1:0] pixel_value;
   logic                             pixel_blank;
   modport source (output valid, pixel_value, pixel_blank, input ready);
   modport sink (input valid, pixel_value, pixel_blank, output ready);
endinterface

interface iwp_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [iwp_pkg::OUT_BITS-1:0]  pooled_value;
   logic                           pooled_blank;
   logic [iwp_pkg::ROW_BITS-1:0]  out_row;
   logic [iwp_pkg::OCOL_BITS-1:0] out_col;
   logic                           frame_done;
   modport source (output valid, pooled_value, pooled_blank, out_row, out_col, frame_done,
                   input ready);
   modport sink (input valid, pooled_value, pooled_blank, out_row, out_col, frame_done,
                 output ready);
endinterface
`default_nettype wire

// File: rtl/image_window_pooling_core.sv
// Image window pooling core: pixels in raster order on req_bus, one pooled beat per
// window on rsp_bus, APB-style configuration on psel/penable/pwrite/paddr/pwdata.
// Beats are taken when valid and ready are both high. Registers: op_mode at 0x0,
// pool_size at 0x4, image_width at 0x8, image_height at 0xC; any write restarts the frame.
// A pixel that closes no window is only written to the band memory. The pixel that
// closes a window starts a scan of the band memory, one entry per cycle through its
// registered read port, over its n window pixels (up to MAX_POOL squared); after the
// decide state, max, min and sum load the result. Mean adds a radix-2 divider with one
// step per quotient bit, PIXEL_BITS + 15 bits at default sizes; median runs one scan per
// pixel bit, twice for an even count. No new pixel is taken until the result is loaded.
// Reset clears position counters, sequencer and output valid; the band memory is not
// cleared, since a window only reads entries written for it.
// A finished result waits in the output register; the core keeps taking pixels while it
// waits, and holds the next window's result until the register is free.
`default_nettype none
module image_window_pooling_core #(
   parameter int MAX_POOL   = 8,
   parameter int MAX_WIDTH  = 1024,
   parameter int PIXEL_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   iwp_req_if.sink                             req_bus,
   iwp_rsp_if.source                           rsp_bus,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [iwp_pkg::CSR_ADDR_BITS-1:0]  paddr,
   input  logic [iwp_pkg::CSR_DATA_BITS-1:0]  pwdata,
   output logic [iwp_pkg::CSR_DATA_BITS-1:0]  prdata,
   output logic                                pready
);
   import iwp_pkg::*;

   localparam int PW = $clog2(MAX_POOL + 1);
   localparam int CW = $clog2(MAX_WIDTH);

   logic [OP_BITS-1:0]  op_mode;
   logic [PW-1:0]       p_last;
   logic [CW-1:0]       w_last;
   logic [ROW_BITS-1:0] h_last;
   logic                cfg_wr;
   logic                req_ready;
   cmd_type             cmd;
   status_type          status;

   iwp_csr #(
      .MAX_POOL  (MAX_POOL),
      .MAX_WIDTH (MAX_WIDTH)
   ) u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .op_mode (op_mode),
      .p_last  (p_last),
      .w_last  (w_last),
      .h_last  (h_last),
      .cfg_wr  (cfg_wr)
   );

   // Sequencer: owns input ready and steps the datapath per window.
   iwp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_ready),
      .op_mode   (op_mode),
      .status    (status),
      .cmd       (cmd)
   );

   // Datapath: band memory, window scan, statistics and the output register.
   iwp_dp #(
      .MAX_POOL   (MAX_POOL),
      .MAX_WIDTH  (MAX_WIDTH),
      .PIXEL_BITS (PIXEL_BITS)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .op_mode      (op_mode),
      .p_last       (p_last),
      .w_last       (w_last),
      .h_last       (h_last),
      .cfg_wr       (cfg_wr),
      .pixel_value  (req_bus.pixel_value),
      .pixel_blank  (req_bus.pixel_blank),
      .rsp_ready    (rsp_bus.ready),
      .rsp_valid    (rsp_bus.valid),
      .pooled_value (rsp_bus.pooled_value),
      .pooled_blank (rsp_bus.pooled_blank),
      .out_row      (rsp_bus.out_row),
      .out_col      (rsp_bus.out_col),
      .frame_done   (rsp_bus.frame_done)
   );

   assign req_bus.ready = req_ready;
endmodule
`default_nettype wire

// File: rtl/iwp_csr.sv
// Configuration registers behind an APB-style port, with clamped window geometry.
// Depends on iwp_pkg.
`default_nettype none
module iwp_csr #(
   parameter int MAX_POOL  = 8,
   parameter int MAX_WIDTH = 1024
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [iwp_pkg::CSR_ADDR_BITS-1:0]  paddr,
   input  logic [iwp_pkg::CSR_DATA_BITS-1:0]  pwdata,
   output logic [iwp_pkg::CSR_DATA_BITS-1:0]  prdata,
   output logic                                pready,
   output logic [iwp_pkg::OP_BITS-1:0]        op_mode,
   output logic [$clog2(MAX_POOL+1)-1:0]       p_last,
   output logic [$clog2(MAX_WIDTH)-1:0]        w_last,
   output logic [iwp_pkg::ROW_BITS-1:0]       h_last,
   output logic                                cfg_wr
);
   import iwp_pkg::*;

   localparam int PW = $clog2(MAX_POOL + 1);
   localparam int CW = $clog2(MAX_WIDTH);

   logic [OP_BITS-1:0]         op_ff;
   logic [POOL_REG_BITS-1:0]   pool_ff;
   logic [WIDTH_REG_BITS-1:0]  width_ff;
   logic [HEIGHT_REG_BITS-1:0] height_ff;
   reg_index_type              index;

   assign pready  = 1'b1;
   assign cfg_wr  = psel && penable && pwrite;
   assign index   = reg_index_type'(paddr[3:2]);
   assign op_mode = op_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         op_ff     <= OP_MAX;
         pool_ff   <= POOL_REG_BITS'(2);
         width_ff  <= WIDTH_REG_BITS'(1024);
         height_ff <= HEIGHT_REG_BITS'(1024);
      end else if (cfg_wr) begin
         unique case (index)
            REG_OP_MODE:      op_ff     <= pwdata[OP_BITS-1:0];
            REG_POOL_SIZE:    pool_ff   <= pwdata[POOL_REG_BITS-1:0];
            REG_IMAGE_WIDTH:  width_ff  <= pwdata[WIDTH_REG_BITS-1:0];
            REG_IMAGE_HEIGHT: height_ff <= pwdata[HEIGHT_REG_BITS-1:0];
         endcase
      end
   end

   always_comb begin
      unique case (index)
         REG_OP_MODE:      prdata = CSR_DATA_BITS'(op_ff);
         REG_POOL_SIZE:    prdata = CSR_DATA_BITS'(pool_ff);
         REG_IMAGE_WIDTH:  prdata = CSR_DATA_BITS'(width_ff);
         REG_IMAGE_HEIGHT: prdata = CSR_DATA_BITS'(height_ff);
      endcase
   end

   // Clamp zero to one, and large pool size and width values to the build limits.
   always_comb begin
      priority if (pool_ff == '0) begin
         p_last = '0;
      end else if (int'(pool_ff) > MAX_POOL) begin
         p_last = PW'(MAX_POOL - 1);
      end else begin
         p_last = PW'(pool_ff - POOL_REG_BITS'(1));
      end
      priority if (width_ff == '0) begin
         w_last = '0;
      end else if (int'(width_ff) > MAX_WIDTH) begin
         w_last = CW'(MAX_WIDTH - 1);
      end else begin
         w_last = CW'(width_ff - WIDTH_REG_BITS'(1));
      end
      h_last = (height_ff == '0) ? '0 : height_ff - HEIGHT_REG_BITS'(1);
   end
endmodule
`default_nettype wire

// File: rtl/iwp_ctrl.sv
// Sequencer of the pooling core: accept, statistics pass, median passes, divide, load.
// Depends on iwp_pkg and the assertion macro header.
`default_nettype none
`include "image_window_pooling_core_defines.svh"
module iwp_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [iwp_pkg::OP_BITS-1:0]  op_mode,
   input  iwp_pkg::status_type          status,
   output iwp_pkg::cmd_type             cmd
);
   import iwp_pkg::*;

   state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
            if (req_valid && status.win_end) begin
               cmd.scan_start = 1'b1;
               state_in       = S_STATS;
            end
         end
         S_STATS: begin
            if (status.pass_done) state_in = S_DECIDE;
         end
         S_DECIDE: begin
            priority if (status.n_zero) begin
               state_in = S_LOAD;
            end else if (op_mode == OP_MEAN) begin
               cmd.div_start = 1'b1;
               state_in      = S_DIV;
            end else if (op_mode == OP_MEDIAN) begin
               cmd.sel_init   = 1'b1;
               cmd.scan_start = 1'b1;
               cmd.scan_sel   = 1'b1;
               state_in       = S_SEL_A;
            end else begin
               state_in = S_LOAD;
            end
         end
         S_SEL_A: begin
            if (status.pass_done) begin
               priority if (!status.sel_last) begin
                  cmd.scan_start = 1'b1;
                  cmd.scan_sel   = 1'b1;
               end else if (!status.n_odd) begin
                  cmd.sel_init    = 1'b1;
                  cmd.sel_round_b = 1'b1;
                  cmd.scan_start  = 1'b1;
                  cmd.scan_sel    = 1'b1;
                  state_in        = S_SEL_B;
               end else begin
                  state_in = S_LOAD;
               end
            end
         end
         S_SEL_B: begin
            if (status.pass_done) begin
               if (!status.sel_last) begin
                  cmd.scan_start = 1'b1;
                  cmd.scan_sel   = 1'b1;
               end else begin
                  state_in = S_LOAD;
               end
            end
         end
         S_DIV: begin
            if (status.div_done) state_in = S_LOAD;
         end
         S_LOAD: begin
            if (status.rsp_free) begin
               cmd.load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   `IWP_ASSERT(a_pass_in_scan, status.pass_done |-> (state_ff == S_STATS || state_ff == S_SEL_A || state_ff == S_SEL_B), "scan pass ended outside a scan state")
   `IWP_ASSERT(a_div_in_div, status.div_done |-> (state_ff == S_DIV), "divider finished outside divide state")
   `IWP_ASSERT(a_load_valid, cmd.load |=> status.rsp_valid, "loaded result not presented")
   `IWP_ASSERT_RESET(a_reset_idle, reset |=> (state_ff == S_IDLE), "sequencer not idle after reset")
endmodule
`default_nettype wire

// File: rtl/iwp_dp.sv
// Datapath of the pooling core: position counters, band memory, window scan,
// statistics, bitwise median selection, mean divider and result register. Depends on iwp_pkg.
`default_nettype none
module iwp_dp #(
   parameter int MAX_POOL   = 8,
   parameter int MAX_WIDTH  = 1024,
   parameter int PIXEL_BITS = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  iwp_pkg::cmd_type               cmd,
   output iwp_pkg::status_type            status,
   input  logic [iwp_pkg::OP_BITS-1:0]    op_mode,
   input  logic [$clog2(MAX_POOL+1)-1:0]   p_last,
   input  logic [$clog2(MAX_WIDTH)-1:0]    w_last,
   input  logic [iwp_pkg::ROW_BITS-1:0]   h_last,
   input  logic                            cfg_wr,
   input  logic [iwp_pkg::PIX_IN_BITS-1:0] pixel_value,
   input  logic                            pixel_blank,
   input  logic                            rsp_ready,
   output logic                            rsp_valid,
   output logic [iwp_pkg::OUT_BITS-1:0]   pooled_value,
   output logic                            pooled_blank,
   output logic [iwp_pkg::ROW_BITS-1:0]   out_row,
   output logic [iwp_pkg::OCOL_BITS-1:0]  out_col,
   output logic                            frame_done
);
   import iwp_pkg::*;

   localparam int PW    = $clog2(MAX_POOL + 1);
   localparam int CW    = $clog2(MAX_WIDTH);
   localparam int DEPTH = MAX_POOL * MAX_WIDTH;
   localparam int AW    = $clog2(DEPTH);
   localparam int NW    = $clog2(MAX_POOL * MAX_POOL + 1);
   localparam int SW    = PIXEL_BITS + NW;
   localparam int RW    = SW + 8;
   localparam int DW    = $clog2(RW + 1);
   localparam int MW    = PIXEL_BITS + 1;

   // position of the next pixel
   logic [CW-1:0]        col_ff;
   logic [ROW_BITS-1:0]  row_ff;
   logic [PW-1:0]        cin_ff, rin_ff;
   logic [OCOL_BITS-1:0] wcol_ff;
   logic [ROW_BITS-1:0]  wrow_ff;
   logic                 col_at_end, row_at_end, cin_end, rin_end;

   // window captured at its last pixel
   logic [PW-1:0]        win_rows_ff, win_cols_ff;
   logic [CW-1:0]        c0_ff;
   logic [ROW_BITS-1:0]  orow_ff;
   logic [OCOL_BITS-1:0] ocol_ff;
   logic                 olast_ff;

   // band memory and scan
   logic [MW-1:0]         band_mem [DEPTH];
   logic [PIXEL_BITS-1:0] pix;
   logic [AW-1:0]         wr_addr, rd_addr;
   logic [MW-1:0]         rd_data_ff;
   logic [PW-1:0]         sr_ff, sc_ff;
   logic [AW-1:0]         rbase_ff;
   logic                  issuing_ff, rd_valid_ff, rd_last_ff, scan_sel_ff;
   logic                  scan_final, pass_done;

   // statistics
   logic [PIXEL_BITS-1:0] x;
   logic                  take;
   logic [NW-1:0]         n_ff;
   logic [SW-1:0]         sum_ff;
   logic [PIXEL_BITS-1:0] mx_ff, mn_ff;

   // median selection
   logic [NW-1:0]         cnt_ff, cnt_next, k_ff;
   logic [PIXEL_BITS-1:0] prefix_ff, mask_ff, bitsel_ff, prefix_next;
   logic [PIXEL_BITS-1:0] med_a_ff, med_b_ff, med_hi;
   logic                  round_b_ff, hit, zero_bit;

   // divider
   logic                  div_busy_ff;
   logic [DW-1:0]         div_cnt_ff;
   logic [RW-1:0]         div_q_ff;
   logic [NW-1:0]         div_r_ff;
   logic [NW:0]           r_sh;
   logic                  r_ge;

   // result
   logic [RW-1:0]         res;
   logic                  rsp_valid_ff;
   logic [OUT_BITS-1:0]   value_ff;
   logic                  blank_ff, done_ff;
   logic [ROW_BITS-1:0]   row_out_ff;
   logic [OCOL_BITS-1:0]  col_out_ff;

   assign col_at_end = (col_ff == w_last);
   assign row_at_end = (row_ff == h_last);
   assign cin_end    = (cin_ff == p_last);
   assign rin_end    = (rin_ff == p_last);

   always_ff @(posedge clock) begin
      if (reset || cfg_wr) begin
         col_ff  <= '0;
         row_ff  <= '0;
         cin_ff  <= '0;
         rin_ff  <= '0;
         wcol_ff <= '0;
         wrow_ff <= '0;
      end else if (cmd.accept) begin
         if (col_at_end) begin
            col_ff  <= '0;
            cin_ff  <= '0;
            wcol_ff <= '0;
            if (row_at_end) begin
               row_ff  <= '0;
               rin_ff  <= '0;
               wrow_ff <= '0;
            end else begin
               row_ff  <= row_ff + ROW_BITS'(1);
               rin_ff  <= rin_end ? '0 : rin_ff + PW'(1);
               wrow_ff <= wrow_ff + ROW_BITS'(rin_end);
            end
         end else begin
            col_ff  <= col_ff + CW'(1);
            cin_ff  <= cin_end ? '0 : cin_ff + PW'(1);
            wcol_ff <= wcol_ff + OCOL_BITS'(cin_end);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         win_rows_ff <= rin_ff;
         win_cols_ff <= cin_ff;
         c0_ff       <= col_ff - CW'(cin_ff);
         orow_ff     <= wrow_ff;
         ocol_ff     <= wcol_ff;
         olast_ff    <= col_at_end && row_at_end;
      end
   end

   // Band memory: one row slot per row of the band.
   assign pix     = PIXEL_BITS'(pixel_value);
   assign wr_addr = AW'(rin_ff) * AW'(MAX_WIDTH) + AW'(col_ff);
   assign rd_addr = rbase_ff + AW'(c0_ff) + AW'(sc_ff);

   always_ff @(posedge clock) begin
      if (cmd.accept) band_mem[wr_addr] <= {pixel_blank, pix};
      rd_data_ff <= band_mem[rd_addr];
   end

   assign scan_final = (sc_ff == win_cols_ff) && (sr_ff == win_rows_ff);
   assign pass_done  = rd_valid_ff && rd_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         issuing_ff  <= 1'b0;
         rd_valid_ff <= 1'b0;
         rd_last_ff  <= 1'b0;
      end else begin
         rd_valid_ff <= issuing_ff;
         rd_last_ff  <= issuing_ff && scan_final;
         if (cmd.scan_start) begin
            issuing_ff  <= 1'b1;
            sr_ff       <= '0;
            sc_ff       <= '0;
            rbase_ff    <= '0;
            scan_sel_ff <= cmd.scan_sel;
         end else if (issuing_ff) begin
            if (sc_ff == win_cols_ff) begin
               sc_ff <= '0;
               if (sr_ff == win_rows_ff) begin
                  issuing_ff <= 1'b0;
               end else begin
                  sr_ff    <= sr_ff + PW'(1);
                  rbase_ff <= rbase_ff + AW'(MAX_WIDTH);
               end
            end else begin
               sc_ff <= sc_ff + PW'(1);
            end
         end
      end
   end

   assign x    = rd_data_ff[PIXEL_BITS-1:0];
   assign take = rd_valid_ff && !rd_data_ff[PIXEL_BITS];

   always_ff @(posedge clock) begin
      if (cmd.scan_start && !cmd.scan_sel) begin
         n_ff   <= '0;
         sum_ff <= '0;
      end else if (take && !scan_sel_ff) begin
         n_ff   <= n_ff + NW'(1);
         sum_ff <= sum_ff + SW'(x);
         if (n_ff == '0 || x > mx_ff) mx_ff <= x;
         if (n_ff == '0 || x < mn_ff) mn_ff <= x;
      end
   end

   // One result bit per pass, most significant first: count values that
   // match the bits chosen so far and have a zero here.
   assign hit         = take && scan_sel_ff && (((x ^ prefix_ff) & mask_ff) == '0)
                        && ((x & bitsel_ff) == '0);
   assign cnt_next    = cnt_ff + NW'(hit);
   assign zero_bit    = (cnt_next > k_ff);
   assign prefix_next = zero_bit ? prefix_ff : (prefix_ff | bitsel_ff);

   always_ff @(posedge clock) begin
      cnt_ff <= cmd.scan_start ? '0 : cnt_next;
      if (pass_done && scan_sel_ff) begin
         if (!zero_bit) k_ff <= k_ff - cnt_next;
         prefix_ff <= prefix_next;
         mask_ff   <= mask_ff | bitsel_ff;
         bitsel_ff <= bitsel_ff >> 1;
         if (bitsel_ff[0]) begin
            if (round_b_ff) med_b_ff <= prefix_next;
            else            med_a_ff <= prefix_next;
         end
      end
      if (cmd.sel_init) begin
         prefix_ff  <= '0;
         mask_ff    <= '0;
         bitsel_ff  <= {1'b1, {(PIXEL_BITS-1){1'b0}}};
         round_b_ff <= cmd.sel_round_b;
         k_ff       <= cmd.sel_round_b ? (n_ff >> 1) : ((n_ff - NW'(1)) >> 1);
      end
   end

   // Restoring divide of (sum * 256 + n / 2) by n, one quotient bit a cycle.
   assign r_sh = {div_r_ff, div_q_ff[RW-1]};
   assign r_ge = (r_sh >= {1'b0, n_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         div_busy_ff <= 1'b0;
      end else if (cmd.div_start) begin
         div_busy_ff <= 1'b1;
         div_cnt_ff  <= '0;
         div_r_ff    <= '0;
         div_q_ff    <= (RW'(sum_ff) << 8) + RW'(n_ff >> 1);
      end else if (div_busy_ff) begin
         div_r_ff   <= r_ge ? NW'(r_sh - {1'b0, n_ff}) : NW'(r_sh);
         div_q_ff   <= {div_q_ff[RW-2:0], r_ge};
         div_cnt_ff <= div_cnt_ff + DW'(1);
         if (div_cnt_ff == DW'(RW - 1)) div_busy_ff <= 1'b0;
      end
   end

   assign med_hi = n_ff[0] ? med_a_ff : med_b_ff;

   always_comb begin
      unique case (op_mode)
         OP_MIN:    res = RW'(mn_ff) << 8;
         OP_SUM:    res = RW'(sum_ff) << 8;
         OP_MEAN:   res = div_q_ff;
         OP_MEDIAN: res = (RW'(med_a_ff) + RW'(med_hi)) << 7;
         default:   res = RW'(mx_ff) << 8;
      endcase
      if (n_ff == '0) res = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         value_ff   <= OUT_BITS'(res);
         blank_ff   <= (n_ff == '0);
         row_out_ff <= orow_ff;
         col_out_ff <= ocol_ff;
         done_ff    <= olast_ff;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign pooled_value = value_ff;
   assign pooled_blank = blank_ff;
   assign out_row      = row_out_ff;
   assign out_col      = col_out_ff;
   assign frame_done   = done_ff;

   assign status.win_end   = (cin_end || col_at_end) && (rin_end || row_at_end);
   assign status.pass_done = pass_done;
   assign status.sel_last  = bitsel_ff[0];
   assign status.n_zero    = (n_ff == '0);
   assign status.n_odd     = n_ff[0];
   assign status.div_done  = div_busy_ff && (div_cnt_ff == DW'(RW - 1));
   assign status.rsp_free  = !rsp_valid_ff || rsp_ready;
   assign status.rsp_valid = rsp_valid_ff;
endmodule
`default_nettype wire
